// ===== rtl/core/ialu_pkg.sv =====
// shared types and codes for the 64-bit integer alu with divide
// no dependencies
package ialu_pkg;

  localparam int unsigned XLEN = 64;
  localparam int unsigned SHIFT_MASK = 63;

  typedef enum logic [4:0] {
    FN_ADD    = 5'd0,
    FN_SUB    = 5'd1,
    FN_MUL    = 5'd2,
    FN_DIV    = 5'd3,
    FN_MOD    = 5'd4,
    FN_AND    = 5'd5,
    FN_OR     = 5'd6,
    FN_XOR    = 5'd7,
    FN_SHL    = 5'd8,
    FN_SHR    = 5'd9,
    FN_EQ     = 5'd10,
    FN_NE     = 5'd11,
    FN_LT     = 5'd12,
    FN_LE     = 5'd13,
    FN_GT     = 5'd14,
    FN_GE     = 5'd15,
    FN_NEG    = 5'd16,
    FN_NOT    = 5'd17,
    FN_LOGNOT = 5'd18
  } func_t;

  typedef enum logic [1:0] {
    UNIT_ALU,
    UNIT_MUL,
    UNIT_DIV,
    UNIT_NONE
  } unit_t;

  // classified request handed from front to back
  typedef struct packed {
    func_t             func;
    unit_t             unit;
    logic              uns;
    logic              b_zero;
    logic [XLEN-1:0]   a;
    logic [XLEN-1:0]   b;
  } req_t;

endpackage

// ===== rtl/core/integer_alu_64_with_divide.sv =====
// top level of the 64-bit integer alu with divide
// depends on ialu_pkg, ialu_front, ialu_queue, ialu_back
//
// usage
//   in_* channel: one request per accepted valid/ready beat, carrying the
//   operation code, two 64-bit operands and the unsigned flag.
//   out_* channel: one result per request, in request order, with the
//   64-bit result and valid_res (low on divide by zero or an unused code,
//   result then zero).
// pipeline and throughput
//   from request accept to out_valid: front register, queue, alu and partial
//   products, product sum, 64 divider stages, output register. every
//   operation runs through the same pipeline, set by the one-bit-per-stage
//   divider, so one request is taken every cycle while no result is held.
// reset
//   rst_n low clears all valid bits in front, queue and back; no requests or
//   results are held afterwards.
// stall
//   while a result waits on out_ready the back pipeline holds; the front and
//   the queue keep taking requests until the queue fills, then in_ready drops.
module integer_alu_64_with_divide #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [4:0]   in_func,
  input  logic [63:0]  in_operand_a,
  input  logic [63:0]  in_operand_b,
  input  logic         in_unsigned_mode,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [63:0]  out_result,
  output logic         out_valid_res
);

  logic              f_vld, f_rdy, q_vld, q_rdy;
  ialu_pkg::req_t    f_req, q_req;

  // front end
  ialu_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_func, .in_operand_a,
    .in_operand_b, .in_unsigned_mode,
    .req_vld (f_vld), .req_rdy (f_rdy), .req (f_req)
  );

  // queue
  ialu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n,
    .push_vld (f_vld), .push_rdy (f_rdy), .push_data (f_req),
    .pop_vld (q_vld), .pop_rdy (q_rdy), .pop_data (q_req)
  );

  // back end
  ialu_back u_back (
    .clk, .rst_n,
    .req_vld (q_vld), .req_rdy (q_rdy), .req (q_req),
    .out_valid, .out_ready, .out_result, .out_valid_res
  );

`ifndef NO_ASSERTIONS
  // a failed result carries zero bits
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_valid_res) |-> (out_result == '0))
    else $error("invalid result with nonzero bits");

  // back does not pull from the queue while a result is held
  a_hold_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !q_rdy)
    else $error("queue popped during output stall");

  // a request left in the front stalls the input when the queue is full
  a_front_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (f_vld && !f_rdy) |-> !in_ready)
    else $error("input taken while front request blocked");
`endif

endmodule

// ===== rtl/core/ialu_front.sv =====
// front end: accepts requests, classifies them by execution unit
// depends on ialu_pkg
module ialu_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [4:0]        in_func,
  input  logic [63:0]       in_operand_a,
  input  logic [63:0]       in_operand_b,
  input  logic              in_unsigned_mode,
  output logic              req_vld,
  input  logic              req_rdy,
  output ialu_pkg::req_t    req
);

  logic              vld_r;
  ialu_pkg::req_t    req_r;
  ialu_pkg::req_t    req_nxt;

  assign in_ready = !vld_r || req_rdy;
  assign req_vld  = vld_r;
  assign req      = req_r;

  // decode the operation into a unit
  always_comb begin
    req_nxt.func   = ialu_pkg::func_t'(in_func);
    req_nxt.uns    = in_unsigned_mode;
    req_nxt.a      = in_operand_a;
    req_nxt.b      = in_operand_b;
    req_nxt.b_zero = (in_operand_b == '0);
    case (ialu_pkg::func_t'(in_func))
      ialu_pkg::FN_MUL: req_nxt.unit = ialu_pkg::UNIT_MUL;
      ialu_pkg::FN_DIV,
      ialu_pkg::FN_MOD: req_nxt.unit = ialu_pkg::UNIT_DIV;
      ialu_pkg::FN_ADD, ialu_pkg::FN_SUB, ialu_pkg::FN_AND, ialu_pkg::FN_OR,
      ialu_pkg::FN_XOR, ialu_pkg::FN_SHL, ialu_pkg::FN_SHR, ialu_pkg::FN_EQ,
      ialu_pkg::FN_NE, ialu_pkg::FN_LT, ialu_pkg::FN_LE, ialu_pkg::FN_GT,
      ialu_pkg::FN_GE, ialu_pkg::FN_NEG, ialu_pkg::FN_NOT,
      ialu_pkg::FN_LOGNOT: req_nxt.unit = ialu_pkg::UNIT_ALU;
      default: req_nxt.unit = ialu_pkg::UNIT_NONE;
    endcase
  end

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      req_r <= req_nxt;
    end
  end

endmodule

// ===== rtl/core/ialu_queue.sv =====
// small request queue between front and back
// depends on ialu_pkg
module ialu_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_vld,
  output logic              push_rdy,
  input  ialu_pkg::req_t    push_data,
  output logic              pop_vld,
  input  logic              pop_rdy,
  output ialu_pkg::req_t    pop_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ialu_pkg::req_t    mem_r [DEPTH];
  logic [PW-1:0]     wr_r, rd_r;
  logic [CW-1:0]     cnt_r;
  logic              push, pop;

  assign push_rdy = (cnt_r != CW'(DEPTH));
  assign pop_vld  = (cnt_r != '0);
  assign pop_data = mem_r[rd_r];
  assign push     = push_vld && push_rdy;
  assign pop      = pop_vld && pop_rdy;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      if (pop)  rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/ialu_back.sv =====
// back end: alu, split multiplier and one-bit-per-stage divider pipeline
// depends on ialu_pkg
module ialu_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_vld,
  output logic              req_rdy,
  input  ialu_pkg::req_t    req,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [63:0]       out_result,
  output logic              out_valid_res
);

  localparam int unsigned N = ialu_pkg::XLEN;

  typedef struct packed {
    logic          is_mul;
    logic          is_div;
    logic          sel_rem;
    logic          ok;
    logic          neg_q;
    logic          neg_r;
    logic [N-1:0]  res;
    logic [N-1:0]  dvs;
    logic [N-1:0]  pp_ll;
    logic [31:0]   pp_lh;
    logic [31:0]   pp_hl;
  } p1_t;

  typedef struct packed {
    logic          is_div;
    logic          sel_rem;
    logic          ok;
    logic          neg_q;
    logic          neg_r;
    logic [N-1:0]  rem;
    logic [N-1:0]  quo;
    logic [N-1:0]  dvs;
  } dstg_t;

  logic          en;
  p1_t           p1_nxt, p1_r;
  logic          p1_vld_r;
  dstg_t         stg_r [N+1];
  logic          vld_r [N+1];
  logic          out_vld_r;
  logic [N-1:0]  out_res_r, res_fin;
  logic          out_ok_r;
  logic [5:0]    sh;
  logic          lt, gt;
  logic [N-1:0]  a, b;

  // whole pipeline advances unless the output is held
  assign en      = !out_vld_r || out_ready;
  assign req_rdy = en;

  assign a  = req.a;
  assign b  = req.b;
  assign sh = b[5:0];
  assign lt = req.uns ? (a < b) : ($signed(a) < $signed(b));
  assign gt = req.uns ? (b < a) : ($signed(b) < $signed(a));

  // first stage: alu result, partial products, divider operands
  always_comb begin
    p1_nxt.is_mul  = (req.unit == ialu_pkg::UNIT_MUL);
    p1_nxt.is_div  = (req.unit == ialu_pkg::UNIT_DIV);
    p1_nxt.sel_rem = (req.func == ialu_pkg::FN_MOD);
    p1_nxt.ok      = (req.unit != ialu_pkg::UNIT_NONE) &&
                     !((req.unit == ialu_pkg::UNIT_DIV) && req.b_zero);
    p1_nxt.neg_q   = !req.uns && (a[N-1] ^ b[N-1]);
    p1_nxt.neg_r   = !req.uns && a[N-1];
    p1_nxt.dvs     = (!req.uns && b[N-1]) ? (N'(0) - b) : b;
    p1_nxt.pp_ll   = N'(a[31:0] * b[31:0]);
    p1_nxt.pp_lh   = 32'(a[31:0] * b[63:32]);
    p1_nxt.pp_hl   = 32'(a[63:32] * b[31:0]);
    case (req.func)
      ialu_pkg::FN_ADD:    p1_nxt.res = a + b;
      ialu_pkg::FN_SUB:    p1_nxt.res = a - b;
      ialu_pkg::FN_DIV,
      ialu_pkg::FN_MOD:    p1_nxt.res = (!req.uns && a[N-1]) ? (N'(0) - a) : a;
      ialu_pkg::FN_AND:    p1_nxt.res = a & b;
      ialu_pkg::FN_OR:     p1_nxt.res = a | b;
      ialu_pkg::FN_XOR:    p1_nxt.res = a ^ b;
      ialu_pkg::FN_SHL:    p1_nxt.res = a << sh;
      ialu_pkg::FN_SHR:    p1_nxt.res = req.uns ? (a >> sh) : N'($signed(a) >>> sh);
      ialu_pkg::FN_EQ:     p1_nxt.res = N'(a == b);
      ialu_pkg::FN_NE:     p1_nxt.res = N'(a != b);
      ialu_pkg::FN_LT:     p1_nxt.res = N'(lt);
      ialu_pkg::FN_LE:     p1_nxt.res = N'(!gt);
      ialu_pkg::FN_GT:     p1_nxt.res = N'(gt);
      ialu_pkg::FN_GE:     p1_nxt.res = N'(!lt);
      ialu_pkg::FN_NEG:    p1_nxt.res = N'(0) - a;
      ialu_pkg::FN_NOT:    p1_nxt.res = ~a;
      ialu_pkg::FN_LOGNOT: p1_nxt.res = N'(a == '0);
      default:             p1_nxt.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r <= req_vld;
    end
    if (en) begin
      p1_r <= p1_nxt;
    end
  end

  // second stage: sum the partial products, load the divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= p1_vld_r;
    end
    if (en) begin
      stg_r[0].is_div  <= p1_r.is_div;
      stg_r[0].sel_rem <= p1_r.sel_rem;
      stg_r[0].ok      <= p1_r.ok;
      stg_r[0].neg_q   <= p1_r.neg_q;
      stg_r[0].neg_r   <= p1_r.neg_r;
      stg_r[0].rem     <= '0;
      stg_r[0].dvs     <= p1_r.dvs;
      stg_r[0].quo     <= p1_r.is_mul ?
                          (p1_r.pp_ll + {(p1_r.pp_lh + p1_r.pp_hl), 32'd0}) : p1_r.res;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 1; k <= N; k++) begin : g_div
    logic [N:0]  trial;
    logic [N:0]  diff;
    dstg_t       stg_nxt;
    assign trial = {stg_r[k-1].rem, stg_r[k-1].quo[N-1]};
    assign diff  = trial - {1'b0, stg_r[k-1].dvs};

    // next stage contents
    always_comb begin
      stg_nxt = stg_r[k-1];
      if (stg_r[k-1].is_div) begin
        if (!diff[N]) begin
          stg_nxt.rem = diff[N-1:0];
          stg_nxt.quo = {stg_r[k-1].quo[N-2:0], 1'b1};
        end else begin
          stg_nxt.rem = trial[N-1:0];
          stg_nxt.quo = {stg_r[k-1].quo[N-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
      if (en) begin
        stg_r[k] <= stg_nxt;
      end
    end
  end

  // sign fix-up and result select
  always_comb begin
    if (!stg_r[N].ok) begin
      res_fin = '0;
    end else if (!stg_r[N].is_div) begin
      res_fin = stg_r[N].quo;
    end else if (stg_r[N].sel_rem) begin
      res_fin = stg_r[N].neg_r ? (N'(0) - stg_r[N].rem) : stg_r[N].rem;
    end else begin
      res_fin = stg_r[N].neg_q ? (N'(0) - stg_r[N].quo) : stg_r[N].quo;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[N];
    end
    if (en) begin
      out_res_r <= res_fin;
      out_ok_r  <= stg_r[N].ok;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_result    = out_res_r;
  assign out_valid_res = out_ok_r;

endmodule

// ===== tb/tb_top.sv =====
// testbench for the 64-bit integer alu with divide: directed and random requests,
// results checked in order against an in-bench predictor; depends on ialu_pkg
`timescale 1ns / 100ps

module tb_top;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [4:0]  in_func = '0;
  logic [63:0] in_operand_a = '0;
  logic [63:0] in_operand_b = '0;
  logic        in_unsigned_mode = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_result;
  logic        out_valid_res;

  typedef struct packed {
    logic [63:0] result;
    logic        valid_res;
  } alu_res_t;

  alu_res_t    expected_q[$];
  int          errors = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          n_sent = 0;
  int          n_checked = 0;
  longint      cycles = 0;

  localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX64 = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] ONES  = '1;

  integer_alu_64_with_divide i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .in_unsigned_mode(in_unsigned_mode),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result(out_result), .out_valid_res(out_valid_res)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("integer_alu_64_with_divide: mismatch");
      $finish;
    end
  end

  function automatic logic [63:0] mag(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  // expected result of one request
  function automatic alu_res_t alu_predict(logic [4:0] fn, logic [63:0] a,
                                           logic [63:0] b, logic uns);
    alu_res_t    r;
    logic [5:0]  sh;
    logic        lt;
    logic        gt;
    logic [63:0] q;
    sh = b[5:0];
    lt = uns ? (a < b) : ($signed(a) < $signed(b));
    gt = uns ? (b < a) : ($signed(b) < $signed(a));
    r.result = '0;
    r.valid_res = 1'b1;
    case (fn)
      ialu_pkg::FN_ADD: r.result = a + b;
      ialu_pkg::FN_SUB: r.result = a - b;
      ialu_pkg::FN_MUL: r.result = a * b;
      ialu_pkg::FN_DIV, ialu_pkg::FN_MOD: begin
        if (b == '0) begin
          r.valid_res = 1'b0;
        end else if (uns) begin
          r.result = (fn == ialu_pkg::FN_DIV) ? a / b : a % b;
        end else if (fn == ialu_pkg::FN_DIV) begin
          q = mag(a) / mag(b);
          r.result = (a[63] ^ b[63]) ? -q : q;
        end else begin
          q = mag(a) % mag(b);
          r.result = a[63] ? -q : q;
        end
      end
      ialu_pkg::FN_AND: r.result = a & b;
      ialu_pkg::FN_OR:  r.result = a | b;
      ialu_pkg::FN_XOR: r.result = a ^ b;
      ialu_pkg::FN_SHL: r.result = a << sh;
      ialu_pkg::FN_SHR: r.result = uns ? a >> sh : $unsigned($signed(a) >>> sh);
      ialu_pkg::FN_EQ:  r.result = {63'd0, a == b};
      ialu_pkg::FN_NE:  r.result = {63'd0, a != b};
      ialu_pkg::FN_LT:  r.result = {63'd0, lt};
      ialu_pkg::FN_LE:  r.result = {63'd0, !gt};
      ialu_pkg::FN_GT:  r.result = {63'd0, gt};
      ialu_pkg::FN_GE:  r.result = {63'd0, !lt};
      ialu_pkg::FN_NEG: r.result = -a;
      ialu_pkg::FN_NOT: r.result = ~a;
      ialu_pkg::FN_LOGNOT: r.result = {63'd0, a == '0};
      default: r.valid_res = 1'b0;
    endcase
    return r;
  endfunction

  // send one request and record its expected result
  task automatic send_request(logic [4:0] fn, logic [63:0] a, logic [63:0] b, logic uns);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= fn;
    in_operand_a <= a;
    in_operand_b <= b;
    in_unsigned_mode <= uns;
    expected_q.push_back(alu_predict(fn, a, b, uns));
    n_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // result checker
  always @(posedge clk) begin
    alu_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("result with no request pending: %h", out_result);
        errors++;
      end else begin
        e = expected_q.pop_front();
        n_checked++;
        if (out_result !== e.result) begin
          $error("result: expected %h, actual %h", e.result, out_result);
          errors++;
        end
        if (out_valid_res !== e.valid_res) begin
          $error("valid_res: expected %b, actual %b", e.valid_res, out_valid_res);
          errors++;
        end
      end
    end
  end

  function automatic logic [63:0] rand_operand();
    case ($urandom_range(7))
      0: return MIN64;
      1: return MAX64;
      2: return ONES;
      3: return 64'd0;
      4: return {56'd0, 8'($urandom())};
      5: return -{56'd0, 8'($urandom())};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // extremes of operands, every operation and the division corners
  task automatic test_directed();
    for (int f = 0; f <= 18; f++)
      send_request(5'(f), MIN64, ONES, f[0]);
    send_request(ialu_pkg::FN_DIV, 64'd7, 64'd0, 1'b0);
    send_request(ialu_pkg::FN_MOD, -64'sd7, 64'd2, 1'b0);
    send_request(ialu_pkg::FN_DIV, -64'sd7, 64'd2, 1'b0);
    send_request(ialu_pkg::FN_SHR, MIN64, 64'd63, 1'b0);
    send_request(ialu_pkg::FN_SHR, MIN64, 64'd0, 1'b1);
    send_request(5'd31, MAX64, MAX64, 1'b1);
  endtask

  // random requests, some with unused codes, some divisions with a zero divisor
  task automatic test_random(int n);
    logic [4:0] fn;
    logic [63:0] b;
    for (int i = 0; i < n; i++) begin
      fn = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(18));
      b = rand_operand();
      if (fn inside {ialu_pkg::FN_DIV, ialu_pkg::FN_MOD} && $urandom_range(5) == 0) b = '0;
      send_request(fn, rand_operand(), b, 1'($urandom()));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle = 6;
    recv_idle = 78;
    test_directed();
    test_random(250);
    send_idle = 78;
    recv_idle = 6;
    test_random(250);
    send_idle = 0;
    recv_idle = 0;
    test_random(250);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("covered %0d requests over all operations, %0d results checked",
             n_sent, n_checked);
    if (errors == 0) begin
      $display("integer_alu_64_with_divide: match");
    end else begin
      $display("integer_alu_64_with_divide: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ialu_pkg.sv
rtl/core/ialu_front.sv
rtl/core/ialu_queue.sv
rtl/core/ialu_back.sv
rtl/core/integer_alu_64_with_divide.sv
tb/tb_top.sv
